[sv/sitda_pkg.sv]
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types, constants and the microprogram for the signed integer to
// decimal text converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int BIN_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(BIN_W + 1);
    localparam int DCNT_W     = $clog2(NUM_DIGITS + 1);
    localparam int CHAR_W     = 7;
    localparam int PC_W       = 3;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

    // Datapath operations selected by a control word.
    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_IDLE   = 3'd1;
    localparam logic [2:0] OP_DABBLE = 3'd2;
    localparam logic [2:0] OP_SKIPZ  = 3'd3;
    localparam logic [2:0] OP_SIGN   = 3'd4;
    localparam logic [2:0] OP_DIGIT  = 3'd5;

    // Sequencing conditions.
    localparam logic [1:0] CND_NEXT = 2'd0;
    localparam logic [1:0] CND_LOOP = 2'd1;
    localparam logic [1:0] CND_JUMP = 2'd2;

    // Step addresses of the microprogram.
    localparam logic [PC_W-1:0] STEP_IDLE   = 3'd0;
    localparam logic [PC_W-1:0] STEP_DABBLE = 3'd1;
    localparam logic [PC_W-1:0] STEP_SKIPZ  = 3'd2;
    localparam logic [PC_W-1:0] STEP_SIGN   = 3'd3;
    localparam logic [PC_W-1:0] STEP_DIGIT  = 3'd4;
    localparam logic [PC_W-1:0] STEP_DONE   = 3'd5;

    typedef struct packed {
        logic [2:0]      op;
        logic [1:0]      cond;
        logic [PC_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic hold;
        logic again;
    } t_stat;

    function automatic t_ctrl ucode_word(input logic [PC_W-1:0] pc);
        t_ctrl w;
        unique case (pc)
            STEP_IDLE:   w = '{op: OP_IDLE,   cond: CND_NEXT, target: STEP_IDLE};
            STEP_DABBLE: w = '{op: OP_DABBLE, cond: CND_LOOP, target: STEP_DABBLE};
            STEP_SKIPZ:  w = '{op: OP_SKIPZ,  cond: CND_LOOP, target: STEP_SKIPZ};
            STEP_SIGN:   w = '{op: OP_SIGN,   cond: CND_NEXT, target: STEP_IDLE};
            STEP_DIGIT:  w = '{op: OP_DIGIT,  cond: CND_LOOP, target: STEP_DIGIT};
            STEP_DONE:   w = '{op: OP_NOP,    cond: CND_JUMP, target: STEP_IDLE};
            default:     w = '{op: OP_NOP,    cond: CND_JUMP, target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

[sv/signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ASCII text, one character
// per output word, most significant first, with the last character flagged.
// ----------------------------------------------------------------------------
// Each item passes through one load step, 32 shift-and-add-3 steps,
// leading-zero removal, the sign step, one step per digit and one return step
// to idle; the sign and digit steps hold while the output is stalled, and no
// new item is taken until the block is back in idle. Synchronous active-low
// reset returns the step counter to idle and empties the output register.
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [BIN_W-1:0] i_value,
    output logic                    o_stall,
    output logic                    o_valid,
    output logic [CHAR_W-1:0]       o_text_char,
    output logic                    o_is_last,
    input  logic                    i_stall
);

    t_ctrl w_ctrl;
    t_stat w_stat;

    sitda_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    sitda_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_valid     (i_valid),
        .i_value     (i_value),
        .i_stall     (i_stall),
        .o_stat      (w_stat),
        .o_valid     (o_valid),
        .o_text_char (o_text_char),
        .o_is_last   (o_is_last)
    );

    // A new word is taken only while the sequencer waits in its idle step.
    assign o_stall = (w_ctrl.op != OP_IDLE);

    // Once a word is taken the block stays busy for the conversion.
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again right after a load");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_text_char == CHAR_MINUS) ||
                    ((o_text_char >= CHAR_ZERO) && (o_text_char <= CHAR_ZERO + 7'd9)))
        else $error("output character is neither a sign nor a digit");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_text_char == CHAR_MINUS)) |-> !o_is_last)
        else $error("minus sign flagged as last character");

    // The sign and all digits are emitted before the block returns to idle.
    a_no_load_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_IDLE) && o_valid |-> o_is_last)
        else $error("idle while a non-final character is pending");

endmodule

[sv/sitda_seq.sv]
// ----------------------------------------------------------------------------
// sitda_seq
// Step counter and microprogram store. Picks the next step from the control
// word's condition and the status reported by the datapath.
// ----------------------------------------------------------------------------
module sitda_seq
    import sitda_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctrl           w_ctrl;

    assign w_ctrl = ucode_word(r_pc);
    assign o_ctrl = w_ctrl;

    always_comb begin
        n_pc = r_pc;
        if (!i_stat.hold) begin
            unique case (w_ctrl.cond)
                CND_NEXT: n_pc = r_pc + 1'b1;
                CND_LOOP: n_pc = i_stat.again ? w_ctrl.target : r_pc + 1'b1;
                CND_JUMP: n_pc = w_ctrl.target;
                default:  n_pc = STEP_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

[sv/sitda_dp.sv]
// ----------------------------------------------------------------------------
// sitda_dp
// Datapath: magnitude register, BCD accumulator for shift-and-add-3
// conversion, digit counter and the output word register.
// ----------------------------------------------------------------------------
module sitda_dp
    import sitda_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctrl                    i_ctrl,
    input  logic                     i_valid,
    input  logic signed [BIN_W-1:0]  i_value,
    input  logic                     i_stall,
    output t_stat                    o_stat,
    output logic                     o_valid,
    output logic [CHAR_W-1:0]        o_text_char,
    output logic                     o_is_last
);

    logic [BIN_W-1:0]  r_bin;
    logic [BCD_W-1:0]  r_bcd;
    logic              r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;

    logic [BIN_W-1:0]  w_word;
    logic [BCD_W-1:0]  w_adj;
    logic [3:0]        w_top;
    logic              w_out_free;
    logic              w_emit;
    logic [CHAR_W-1:0] w_emit_char;
    logic              w_emit_last;
    logic              w_skip;

    assign w_word     = $unsigned(i_value);
    assign w_top      = r_bcd[BCD_W-1 -: 4];
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_skip     = (w_top == 4'd0) && (r_dcnt != DCNT_W'(1));

    // Each BCD digit of five or more gets three added before the shift.
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                        : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        o_stat      = '{hold: 1'b0, again: 1'b0};
        w_emit      = 1'b0;
        w_emit_char = CHAR_ZERO + {3'b000, w_top};
        w_emit_last = (r_dcnt == DCNT_W'(1));
        unique case (i_ctrl.op)
            OP_IDLE: begin
                o_stat.hold = !i_valid;
            end
            OP_DABBLE: begin
                o_stat.again = (r_cnt != CNT_W'(1));
            end
            OP_SKIPZ: begin
                o_stat.again = w_skip;
            end
            OP_SIGN: begin
                o_stat.hold = r_neg && !w_out_free;
                w_emit      = r_neg && w_out_free;
                w_emit_char = CHAR_MINUS;
                w_emit_last = 1'b0;
            end
            OP_DIGIT: begin
                o_stat.hold  = !w_out_free;
                o_stat.again = (r_dcnt != DCNT_W'(1));
                w_emit       = w_out_free;
            end
            default: begin
                o_stat = '{hold: 1'b0, again: 1'b0};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            OP_IDLE: begin
                if (i_valid) begin
                    r_neg  <= w_word[BIN_W-1];
                    // The most negative value negates to itself, which is
                    // exactly its magnitude when read as unsigned.
                    r_bin  <= w_word[BIN_W-1] ? (BIN_W'(0) - w_word) : w_word;
                    r_bcd  <= '0;
                    r_cnt  <= CNT_W'(BIN_W);
                    r_dcnt <= DCNT_W'(NUM_DIGITS);
                end
            end
            OP_DABBLE: begin
                r_bcd <= {w_adj[BCD_W-2:0], r_bin[BIN_W-1]};
                r_bin <= {r_bin[BIN_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
            end
            OP_SKIPZ: begin
                if (w_skip) begin
                    r_bcd  <= {r_bcd[BCD_W-5:0], 4'd0};
                    r_dcnt <= r_dcnt - 1'b1;
                end
            end
            OP_DIGIT: begin
                if (w_out_free) begin
                    r_bcd  <= {r_bcd[BCD_W-5:0], 4'd0};
                    r_dcnt <= r_dcnt - 1'b1;
                end
            end
            default: begin
                r_bcd <= r_bcd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_char <= w_emit_char;
            r_out_last <= w_emit_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_text_char = r_out_char;
    assign o_is_last   = r_out_last;

endmodule
